/* hw/rtl/bwsd_pkg.sv */
// Shared types, codes and the case-fold helper for the banned word stream detector.
// No dependencies; imported by bwsd_cell and banned_word_stream_detector_core.
`default_nettype none

package bwsd_pkg;

  // Item kinds carried on the input tuser bit
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Sequencer states of the core
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } st_e;

  // Control broadcast from the core to every window cell
  typedef struct packed {
    logic shift;  // take a new byte from the left neighbor
    logic fold;   // compare letters case-insensitively
  } cell_ctl_t;

  // Map A-Z onto a-z when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bwsd_cell.sv */
// One window cell: holds the message byte at a fixed distance back from the newest byte,
// passes it on to the next cell and checks it against the word character aligned to it.
// Depends on bwsd_pkg.
`default_nettype none

module bwsd_cell
  import bwsd_pkg::*;
#(
  parameter int MAX_LEN  = 16,
  parameter int CELL_IDX = 0
) (
  input  wire logic                                 clk_i,
  input  wire cell_ctl_t                            ctl_i,
  input  wire logic [7:0]                           byte_i,
  output logic      [7:0]                           byte_o,
  input  wire logic [MAX_LEN-1:0][7:0]              chars_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]         len_i,
  output logic                                      ok_o
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);

  logic [7:0]       byte_q;
  logic             in_word;
  logic [LEN_W-1:0] sel_full;
  logic [POS_W-1:0] sel;
  logic [7:0]       wchar;

  // Window byte, shifted one cell further per scanned byte
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // This cell lines up with word character len-1-CELL_IDX
  assign in_word  = (len_i > LEN_W'(CELL_IDX));
  assign sel_full = len_i - LEN_W'(CELL_IDX + 1);
  assign sel      = sel_full[POS_W-1:0];
  assign wchar    = chars_i[sel];

  // Positions outside the word never veto a match
  assign ok_o = !in_word ||
                (fold_byte(wchar, ctl_i.fold) == fold_byte(byte_q, ctl_i.fold));

endmodule

`default_nettype wire

/* hw/rtl/banned_word_stream_detector_core.sv */
// Top level of the banned word stream detector: word table memory, window cell chain,
// sweep sequencer and output register. Depends on bwsd_pkg and bwsd_cell.
`default_nettype none

// Load words (tuser = 0) write one character and the length of one table entry; a length
// of 0 disables the entry. Scan words (tuser = 1) push one message byte into a chain of
// MAX_LEN window cells, then the table is swept one entry per cycle from its single read
// port, comparing every entry against the window in all cells at once; the sweep stops at
// the first entry that matches, and the input is held off until it ends. On the byte
// marked by tlast one result word reports whether any entry occurred in the message and
// the lowest matching index, and the message window starts over; that byte holds the
// input off for as long as the previous result word still waits in the output register.
// Entries whose characters were never written compare unpredictably. fold_case resets to 1
// and is written only between items, while no scan byte is being swept; a write applies
// to scan bytes accepted at the same edge or later.
module banned_word_stream_detector_core
  import bwsd_pkg::*;
#(
  parameter int NUM_WORDS = 16,
  parameter int MAX_LEN   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config register: fold_case
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] word_index, [7:4] char_index, [15:8] char_value, [20:16] word_length
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,  // [0] operation
  input  wire logic        s_axis_tlast,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // [0] banned_found, [4:1] first_word
);

  localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);
  localparam int CHR_W = MAX_LEN * 8;
  localparam int ROW_W = CHR_W + LEN_W;

  // ---------------------------------------------------------------- input unpack
  logic             s_hs;
  logic             scan_go;
  logic             ld_we;
  logic             ld_char_ok;
  logic [3:0]       in_widx;
  logic [3:0]       in_cidx;
  logic [7:0]       in_cval;
  logic [4:0]       in_wlen;
  logic [IDX_W+3:0] widx_ext;
  logic [POS_W+3:0] cidx_ext;
  logic [LEN_W+4:0] wlen_ext;
  logic [IDX_W-1:0] wr_addr;
  logic [POS_W-1:0] wr_pos;
  logic [LEN_W-1:0] wr_len;

  assign in_widx = s_axis_tdata[3:0];
  assign in_cidx = s_axis_tdata[7:4];
  assign in_cval = s_axis_tdata[15:8];
  assign in_wlen = s_axis_tdata[20:16];

  assign widx_ext = {IDX_W'(0), in_widx};
  assign cidx_ext = {POS_W'(0), in_cidx};
  assign wlen_ext = {LEN_W'(0), in_wlen};
  assign wr_addr  = widx_ext[IDX_W-1:0];
  assign wr_pos   = cidx_ext[POS_W-1:0];
  assign wr_len   = (32'(in_wlen) > MAX_LEN) ? LEN_W'(MAX_LEN) : wlen_ext[LEN_W-1:0];

  st_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign scan_go       = s_hs && (s_axis_tuser == OP_SCAN);
  assign ld_we         = s_hs && (s_axis_tuser == OP_LOAD) && (32'(in_widx) < NUM_WORDS);
  assign ld_char_ok    = (32'(in_cidx) < MAX_LEN);

  // ---------------------------------------------------------------- config register
  logic fold_q;

  // Taken only between items so a running sweep keeps its compare mode
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fold_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- word table
  // One row per entry: characters in the low bytes, length on top
  logic [ROW_W-1:0]     word_mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvld_q;
  logic [ROW_W-1:0]     row_q;
  logic                 row_en_q;
  logic [IDX_W-1:0]     addr_q, addr_d;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      word_mem_q[wr_addr][ROW_W-1 -: LEN_W] <= wr_len;
      if (ld_char_ok) begin
        word_mem_q[wr_addr][{wr_pos, 3'b000} +: 8] <= in_cval;
      end
    end
    row_q <= word_mem_q[addr_q];
  end

  // Entries never loaded read as disabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q   <= '0;
      row_en_q <= 1'b0;
    end else begin
      if (ld_we) begin
        wvld_q[wr_addr] <= 1'b1;
      end
      row_en_q <= wvld_q[addr_q];
    end
  end

  logic [MAX_LEN-1:0][7:0] row_chars;
  logic [LEN_W-1:0]        row_len;

  assign row_chars = row_q[CHR_W-1:0];
  assign row_len   = row_en_q ? row_q[ROW_W-1 -: LEN_W] : '0;

  // ---------------------------------------------------------------- window cell chain
  cell_ctl_t           cell_ctl;
  logic [MAX_LEN-1:0]  cell_ok;
  logic [7:0]          cell_byte [MAX_LEN+1];

  assign cell_ctl.shift = scan_go;
  assign cell_ctl.fold  = fold_q;
  assign cell_byte[0]   = in_cval;

  for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
    bwsd_cell #(
      .MAX_LEN  (MAX_LEN),
      .CELL_IDX (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .byte_i  (cell_byte[gi]),
      .byte_o  (cell_byte[gi+1]),
      .chars_i (row_chars),
      .len_i   (row_len),
      .ok_o    (cell_ok[gi])
    );
  end

  // ---------------------------------------------------------------- sweep sequencer
  logic [LEN_W-1:0] fill_q, fill_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] rw_q, rw_d;
  logic             last_q, last_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;
  logic             mv_q, mv_d;
  logic             out_ld;
  logic             hit;

  // Entry in row_q matches the window ending at the newest byte
  assign hit = rv_q && (row_len != '0) && (row_len <= fill_q) && (&cell_ok);

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    rv_d    = 1'b0;
    rw_d    = addr_q;
    last_d  = last_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    fill_d  = fill_q;
    mv_d    = mv_q && !m_axis_tready;
    out_ld  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (scan_go) begin
          state_d = ST_RUN;
          addr_d  = '0;
          last_d  = s_axis_tlast;
          if (fill_q != LEN_W'(MAX_LEN)) begin
            fill_d = fill_q + LEN_W'(1);
          end
        end
      end
      ST_RUN: begin
        rv_d = 1'b1;
        if (addr_q != IDX_W'(NUM_WORDS - 1)) begin
          addr_d = addr_q + IDX_W'(1);
        end
        if (hit) begin
          if (!found_q || (rw_q < fidx_q)) begin
            found_d = 1'b1;
            fidx_d  = rw_q;
          end
          state_d = ST_FIN;
        end else if (rv_q && (rw_q == IDX_W'(NUM_WORDS - 1))) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!mv_q || m_axis_tready) begin
          out_ld  = 1'b1;
          mv_d    = 1'b1;
          found_d = 1'b0;
          fidx_d  = '0;
          fill_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      rv_q    <= 1'b0;
      rw_q    <= '0;
      last_q  <= 1'b0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      fill_q  <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      rv_q    <= rv_d;
      rw_q    <= rw_d;
      last_q  <= last_d;
      found_q <= found_d;
      fidx_q  <= fidx_d;
      fill_q  <= fill_d;
      mv_q    <= mv_d;
    end
  end

  // ---------------------------------------------------------------- output register
  logic             m_found_q;
  logic [3:0]       m_word_q;
  logic [IDX_W+3:0] fidx_ext;

  assign fidx_ext = {4'b0000, fidx_q};

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_found_q <= found_q;
      m_word_q  <= fidx_ext[3:0];
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {3'b000, m_word_q, m_found_q};

  // ---------------------------------------------------------------- assertions
  // A result appears only after the sweep of a final byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN && last_q))
    else $error("result raised outside the end of a message");

  // Window fill count never passes the chain length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(MAX_LEN))
    else $error("window fill count overflow");

  // Evaluated rows always belong to an existing entry
  a_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && rv_q) |-> (32'(rw_q) < NUM_WORDS))
    else $error("sweep evaluated a row beyond the table");

  // An accepted scan byte starts a sweep with a non-empty window
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_go |=> (state_q == ST_RUN && fill_q != '0 && !rv_q))
    else $error("scan byte did not start a sweep");

endmodule

`default_nettype wire
